// File: sv/c2d_pkg.sv
package c2d_pkg;

  // Kernel geometry
  localparam int KERNEL_SIDE = 5;
  localparam int HALF_SIDE   = KERNEL_SIDE / 2;
  localparam int TAP_COUNT   = KERNEL_SIDE * KERNEL_SIDE;
  localparam int TAP_W       = $clog2(TAP_COUNT);
  localparam int SIDE_W      = $clog2(KERNEL_SIDE);

  // Longest image row held in the line memory; out_col is sized for it
  localparam int MAX_WIDTH   = 1024;

  // Configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // Input item function codes
  localparam logic FUNC_COEF  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Gray weights in Q0.16
  localparam logic [23:0] GRAY_R = 24'd19661;
  localparam logic [23:0] GRAY_G = 24'd38666;
  localparam logic [23:0] GRAY_B = 24'd7209;

  // Multiply-accumulate widths
  localparam int COEF_W = 16;
  localparam int PROD_W = COEF_W + 9;
  localparam int ACC_W  = PROD_W + TAP_W;

  typedef struct packed {
    logic              func;
    logic [4:0]        coef_index;
    logic signed [15:0] coef_value;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic [7:0]  filtered;
    logic        run_last;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic tap;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_TAP,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

// File: sv/conv2d_5x5_gray_clamped_unit.sv
// 5x5 convolution on the gray level of an RGB raster stream, border pixels
// replicated, result shifted right 8 and clamped to 0..255. A pixel goes
// through gray conversion and a line-memory write, then for each output it
// completes the 25 window taps go one per cycle through the single read port
// of the line memory and one shared multiply-accumulate, followed by a pipeline
// drain and the output load; a stalled output holds the unit in the load. No new
// item is taken until the last output is loaded. The bottom-right pixel of a
// frame completes up to 9 outputs. The line memory needs no clearing pass after
// reset.
module conv2d_5x5_gray_clamped_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  c2d_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output c2d_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [c2d_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int MAX_WIDTH = c2d_pkg::MAX_WIDTH;
  localparam int K    = c2d_pkg::KERNEL_SIDE;
  localparam int HS   = c2d_pkg::HALF_SIDE;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = (CW + 1 > c2d_pkg::WIDTH_W) ? CW + 1 : c2d_pkg::WIDTH_W;
  localparam int XS_W = WW + 1;
  localparam int HW   = c2d_pkg::HEIGHT_W;
  localparam int YS_W = HW + 2;
  localparam int SW   = c2d_pkg::SIDE_W;
  localparam int TW   = c2d_pkg::TAP_W;
  localparam int MEM_DEPTH = K << CW;
  localparam int MAW  = $clog2(MEM_DEPTH);

  c2d_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [c2d_pkg::WIDTH_W-1:0] width_r;
  logic [HW-1:0]               height_r;

  // Coefficient store
  logic [c2d_pkg::COEF_W-1:0] coef_r   [c2d_pkg::TAP_COUNT];
  logic [c2d_pkg::COEF_W-1:0] coef_nxt [c2d_pkg::TAP_COUNT];

  // Raster position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  // Current pixel transaction
  logic [CW-1:0] px_r, px_nxt;
  logic [HW-1:0] py_r, py_nxt;
  logic [SW-1:0] ps_r, ps_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [7:0]    gray_r, gray_nxt;

  // Output walk
  logic [CW-1:0] c_r, c_nxt, c0_r, c0_nxt, c1_r, c1_nxt;
  logic [HW-1:0] r_r, r_nxt, r0_r, r0_nxt, r1_r, r1_nxt;
  logic [SW-1:0] dxi_r, dxi_nxt, dyi_r, dyi_nxt;

  logic               out_valid_r, out_valid_nxt;
  c2d_pkg::out_item_t out_data_r, out_data_nxt;

  c2d_pkg::mac_ctl_t  mac_ctl;
  logic               mac_busy;
  logic [7:0]         mac_filtered;

  logic               mem_we;
  logic [MAW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]         mem_rdata;

  logic [TW-1:0]      tap_idx;
  logic [CW-1:0]      tap_x;
  logic [SW-1:0]      tap_slot;

  // Window address of the current tap, coordinates clamped to the image
  always_comb begin
    logic [XS_W-1:0] xs;
    logic [YS_W-1:0] ys;
    logic [HW-1:0]   ya;
    logic [SW-1:0]   d;
    logic [SW:0]     sw;
    xs = XS_W'(c_r) + XS_W'(dxi_r);
    if (xs < XS_W'(HS)) begin
      tap_x = '0;
    end else if (xs - XS_W'(HS) >= XS_W'(w_r)) begin
      tap_x = CW'(w_r - WW'(1));
    end else begin
      tap_x = CW'(xs - XS_W'(HS));
    end
    ys = YS_W'(r_r) + YS_W'(dyi_r);
    if (ys < YS_W'(HS)) begin
      ya = '0;
    end else if (ys - YS_W'(HS) >= YS_W'(h_r)) begin
      ya = h_r - HW'(1);
    end else begin
      ya = HW'(ys - YS_W'(HS));
    end
    // Ring slot of that row, counted back from the current row
    d  = SW'(py_r - ya);
    sw = (ps_r >= d) ? (SW+1)'(ps_r - d) : (SW+1)'(ps_r) + (SW+1)'(K) - (SW+1)'(d);
    tap_slot = SW'(sw);
    tap_idx  = TW'(dxi_r * K) + TW'(dyi_r);
  end

  assign mem_raddr = MAW'({tap_slot, tap_x});
  assign mem_waddr = MAW'({ps_r, px_r});

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= c2d_pkg::WIDTH_RESET;
      height_r <= c2d_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2d_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[c2d_pkg::WIDTH_W-1:0];
        c2d_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // Next state and datapath control
  always_comb begin
    logic [WW-1:0]  we;
    logic [HW-1:0]  he;
    logic [WW-1:0]  nx;
    logic [HW:0]    ny;
    logic           row_end, col_end;
    state_nxt     = state_r;
    coef_nxt      = coef_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ps_nxt        = ps_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    gray_nxt      = gray_r;
    c_nxt         = c_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    r_nxt         = r_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    dxi_nxt       = dxi_r;
    dyi_nxt       = dyi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mac_ctl       = '0;
    mem_we        = 1'b0;
    in_stall      = 1'b1;
    we            = '0;
    he            = '0;
    nx            = '0;
    ny            = '0;
    row_end       = 1'b0;
    col_end       = 1'b0;
    unique case (state_r)
      c2d_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.func == c2d_pkg::FUNC_COEF) begin
            if (in_data.coef_index < 5'(c2d_pkg::TAP_COUNT)) begin
              coef_nxt[TW'(in_data.coef_index)] = in_data.coef_value;
            end
          end else begin
            // Effective size, then restart counters that fell outside it
            if (width_r == '0) begin
              we = WW'(1);
            end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
              we = WW'(MAX_WIDTH);
            end else begin
              we = WW'(width_r);
            end
            he = (height_r == '0) ? HW'(1) : height_r;
            w_nxt  = we;
            h_nxt  = he;
            px_nxt = (WW'(col_r) >= we) ? '0 : col_r;
            py_nxt = (row_r >= he) ? '0 : row_r;
            ps_nxt = (row_r >= he) ? '0 : slot_r;
            gray_nxt = 8'((c2d_pkg::GRAY_R * 24'(in_data.red)
                         + c2d_pkg::GRAY_G * 24'(in_data.green)
                         + c2d_pkg::GRAY_B * 24'(in_data.blue)) >> 16);
            state_nxt = c2d_pkg::ST_WR;
          end
        end
      end
      c2d_pkg::ST_WR: begin
        mem_we = 1'b1;
        // Advance the raster position
        nx = WW'(px_r) + WW'(1);
        if (nx >= w_r) begin
          col_nxt = '0;
          ny = (HW+1)'(py_r) + (HW+1)'(1);
          if (ny >= (HW+1)'(h_r)) begin
            row_nxt  = '0;
            slot_nxt = '0;
          end else begin
            row_nxt  = HW'(ny);
            slot_nxt = (ps_r == SW'(K - 1)) ? '0 : ps_r + SW'(1);
          end
        end else begin
          col_nxt  = CW'(nx);
          row_nxt  = py_r;
          slot_nxt = ps_r;
        end
        // Outputs whose last needed pixel is this one
        row_end = (py_r == h_r - HW'(1));
        col_end = (WW'(px_r) == w_r - WW'(1));
        r1_nxt  = row_end ? py_r : py_r - HW'(HS);
        r0_nxt  = (py_r >= HW'(HS)) ? py_r - HW'(HS) : '0;
        c1_nxt  = col_end ? px_r : px_r - CW'(HS);
        c0_nxt  = (px_r >= CW'(HS)) ? px_r - CW'(HS) : '0;
        r_nxt   = r0_nxt;
        c_nxt   = c0_nxt;
        dxi_nxt = '0;
        dyi_nxt = '0;
        if ((row_end || py_r >= HW'(HS)) && (col_end || px_r >= CW'(HS))) begin
          mac_ctl.clear = 1'b1;
          state_nxt     = c2d_pkg::ST_TAP;
        end else begin
          state_nxt = c2d_pkg::ST_IDLE;
        end
      end
      c2d_pkg::ST_TAP: begin
        mac_ctl.tap = 1'b1;
        if (dyi_r == SW'(K - 1)) begin
          dyi_nxt = '0;
          if (dxi_r == SW'(K - 1)) begin
            dxi_nxt   = '0;
            state_nxt = c2d_pkg::ST_DRAIN;
          end else begin
            dxi_nxt = dxi_r + SW'(1);
          end
        end else begin
          dyi_nxt = dyi_r + SW'(1);
        end
      end
      c2d_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = c2d_pkg::ST_FIN;
        end
      end
      c2d_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_col    = 10'(c_r);
          out_data_nxt.out_row    = r_r;
          out_data_nxt.filtered   = mac_filtered;
          out_data_nxt.run_last   = (c_r == c1_r) && (r_r == r1_r);
          out_data_nxt.frame_last = (WW'(c_r) == w_r - WW'(1)) && (r_r == h_r - HW'(1));
          mac_ctl.clear           = 1'b1;
          state_nxt               = c2d_pkg::ST_TAP;
          if (c_r == c1_r) begin
            c_nxt = c0_r;
            if (r_r == r1_r) begin
              state_nxt = c2d_pkg::ST_IDLE;
            end else begin
              r_nxt = r_r + HW'(1);
            end
          end else begin
            c_nxt = c_r + CW'(1);
          end
        end
      end
      default: state_nxt = c2d_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= c2d_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < c2d_pkg::TAP_COUNT; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      coef_r      <= coef_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    ps_r       <= ps_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    gray_r     <= gray_nxt;
    c_r        <= c_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    r_r        <= r_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    dxi_r      <= dxi_nxt;
    dyi_r      <= dyi_nxt;
    out_data_r <= out_data_nxt;
  end

  // Gray line ring: K rows of the image
  c2d_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_lines (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(gray_r),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  c2d_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .coef    ($signed(coef_r[tap_idx])),
    .gray    (mem_rdata),
    .busy    (mac_busy),
    .filtered(mac_filtered)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/c2d_ram.sv
module c2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/c2d_mac.sv
module c2d_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  c2d_pkg::mac_ctl_t                   ctl,
  input  logic signed [c2d_pkg::COEF_W-1:0]   coef,
  input  logic [7:0]                          gray,
  output logic                                busy,
  output logic [7:0]                          filtered
);

  localparam int PW = c2d_pkg::PROD_W;
  localparam int AW = c2d_pkg::ACC_W;

  logic                 v1_r, v2_r;
  logic signed [c2d_pkg::COEF_W-1:0] coef_d_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;

  // Product of the delayed coefficient and the gray value that the memory read returns for it
  assign prod_nxt = $signed({{(PW-c2d_pkg::COEF_W){coef_d_r[c2d_pkg::COEF_W-1]}}, coef_d_r})
                  * $signed({{(PW-8){1'b0}}, gray});

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + {{(AW-PW){prod_r[PW-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.tap;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    coef_d_r <= coef;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
  end

  assign busy = v1_r | v2_r;

  // Shift right by 8 and clamp to 0..255
  always_comb begin
    if (acc_r[AW-1]) begin
      filtered = 8'd0;
    end else if (|acc_r[AW-2:16]) begin
      filtered = 8'd255;
    end else begin
      filtered = acc_r[15:8];
    end
  end

endmodule
